[hdl/periodic_pulse_waveform_unit_defines.svh]
// Assertion macros shared by the pulse waveform unit.
// Depends on nothing; included by files that assert.
`ifndef PERIODIC_PULSE_WAVEFORM_UNIT_DEFINES_SVH
`define PERIODIC_PULSE_WAVEFORM_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define PPW_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the following cycle.
`define PPW_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[hdl/ppw_pkg.sv]
// Shared types and register indexes of the pulse waveform unit.
// Depends on nothing.
`timescale 1ns / 1ps
package ppw_pkg;
    localparam int CFG_IDX_BITS = 3;
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_BASE   = 3'd0,
        REG_PEAK   = 3'd1,
        REG_DELAY  = 3'd2,
        REG_RISE   = 3'd3,
        REG_WIDTH  = 3'd4,
        REG_FALL   = 3'd5,
        REG_PERIOD = 3'd6
    } t_reg_idx;
    // Segment of the pulse that a phase falls into.
    typedef enum logic [1:0] {
        SEG_BASE = 2'd0,
        SEG_RISE = 2'd1,
        SEG_PEAK = 2'd2,
        SEG_FALL = 2'd3
    } t_seg;
endpackage

[hdl/ppw_divider.sv]
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on nothing.
`timescale 1ns / 1ps
module ppw_divider #(
    parameter int NUM_BITS = 64,
    parameter int DEN_BITS = 32,
    parameter int SIDE_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [NUM_BITS-1:0]  i_num,
    input  logic [DEN_BITS-1:0]  i_den,
    input  logic [SIDE_BITS-1:0] i_side,
    output logic                 o_valid,
    output logic [NUM_BITS-1:0]  o_quot,
    output logic [DEN_BITS-1:0]  o_rem,
    output logic [SIDE_BITS-1:0] o_side
);
    // Stage k holds the partial remainder and the numerator, with quotient bits shifted in.
    logic [NUM_BITS:0]    r_v;
    logic [DEN_BITS-1:0]  r_rem  [NUM_BITS+1];
    logic [NUM_BITS-1:0]  r_num  [NUM_BITS+1];
    logic [DEN_BITS-1:0]  r_den  [NUM_BITS+1];
    logic [SIDE_BITS-1:0] r_side [NUM_BITS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NUM_BITS-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_num[0]  <= i_num;
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < NUM_BITS; k++) begin : g_stage
        logic [DEN_BITS:0] w_t;
        logic [DEN_BITS:0] w_d;
        assign w_t = {r_rem[k], r_num[k][NUM_BITS-1]};
        assign w_d = {1'b0, r_den[k]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_t >= w_d) begin
                    r_rem[k+1] <= DEN_BITS'(w_t - w_d);
                    r_num[k+1] <= {r_num[k][NUM_BITS-2:0], 1'b1};
                end else begin
                    r_rem[k+1] <= w_t[DEN_BITS-1:0];
                    r_num[k+1] <= {r_num[k][NUM_BITS-2:0], 1'b0};
                end
                r_den[k+1]  <= r_den[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_v[NUM_BITS];
    assign o_quot  = r_num[NUM_BITS];
    assign o_rem   = r_rem[NUM_BITS];
    assign o_side  = r_side[NUM_BITS];
endmodule

[hdl/periodic_pulse_waveform_unit.sv]
// Top level of the periodic trapezoid pulse unit: registers, phase and ramp pipeline.
// Depends on ppw_pkg, ppw_divider and the assertion macro header.
//
//  channel | signals                        | direction
//  in      | i_in_valid/o_in_ready, time    | into block
//  out     | o_out_valid/i_out_ready, level | out of block
//  cfg     | i_cfg_valid/o_cfg_ready, idx   | into block
//
// One word enters per cycle while the output is not stalled; the phase modulo
// divider takes TIME_BITS+1 stages, the ramp divider takes TIME_BITS+LEVEL_BITS+2,
// and the delay, segment, product and level stages one each.
// Synchronous active-low reset clears valid bits and the configuration registers.
// A stall at the output freezes the whole pipeline; the output register holds
// its word, so nothing is lost or repeated.
`timescale 1ns / 1ps
`include "periodic_pulse_waveform_unit_defines.svh"
module periodic_pulse_waveform_unit
    import ppw_pkg::*;
#(
    parameter int TIME_BITS = 32,
    parameter int LEVEL_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [TIME_BITS-1:0]         i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [TIME_BITS-1:0]         i_time_now,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [LEVEL_BITS-1:0] o_level_out
);
    localparam int DW = LEVEL_BITS + 1;
    localparam int PW = DW + TIME_BITS;
    localparam int SW = 2 * LEVEL_BITS + 2;

    logic signed [LEVEL_BITS-1:0] r_base, r_peak;
    logic [TIME_BITS-1:0] r_delay, r_rise, r_width, r_fall, r_period;
    logic w_en;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0; r_peak <= '0; r_delay <= '0; r_rise <= '0;
            r_width <= '0; r_fall <= '0; r_period <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BASE:   r_base   <= i_cfg_data[LEVEL_BITS-1:0];
                REG_PEAK:   r_peak   <= i_cfg_data[LEVEL_BITS-1:0];
                REG_DELAY:  r_delay  <= i_cfg_data;
                REG_RISE:   r_rise   <= i_cfg_data;
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_FALL:   r_fall   <= i_cfg_data;
                REG_PERIOD: r_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline advances together unless the output word is held.
    assign w_en = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // Stage A: subtract delay, flag the base-only cases.
    logic r_a_v, r_a_base;
    logic [TIME_BITS-1:0] r_a_t;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_v <= 1'b0;
        else if (w_en) r_a_v <= i_in_valid;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_t    <= i_time_now - r_delay;
            r_a_base <= (i_time_now < r_delay) || (r_period == '0);
        end
    end

    // Phase modulo; a zero period gives garbage that the flag overrides.
    logic w_m_v, w_m_base;
    logic [TIME_BITS-1:0] w_m_q, w_m_ph;
    ppw_divider #(.NUM_BITS(TIME_BITS), .DEN_BITS(TIME_BITS), .SIDE_BITS(1)) u_mod (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r_a_v), .i_num(r_a_t),
        .i_den(r_period), .i_side(r_a_base), .o_valid(w_m_v), .o_quot(w_m_q),
        .o_rem(w_m_ph), .o_side(w_m_base)
    );

    // Stage B: pick the segment and the ramp operands.
    logic [TIME_BITS:0] w_p1, w_p2;
    t_seg w_seg;
    logic [TIME_BITS-1:0] w_num, w_den;
    logic signed [LEVEL_BITS-1:0] w_from, w_to;
    always_comb begin
        w_p1 = {1'b0, w_m_ph} - {1'b0, r_rise};
        w_p2 = w_p1 - {1'b0, r_width};
        w_num = '0; w_den = {{(TIME_BITS-1){1'b0}}, 1'b1};
        w_from = r_base; w_to = r_base;
        if (w_m_base) begin
            w_seg = SEG_BASE;
        end else if (w_m_ph < r_rise) begin
            w_seg = SEG_RISE; w_num = w_m_ph; w_den = r_rise; w_to = r_peak;
        end else if (w_p1[TIME_BITS-1:0] < r_width) begin
            w_seg = SEG_PEAK; w_to = r_peak;
        end else if (w_p2[TIME_BITS-1:0] < r_fall) begin
            w_seg = SEG_FALL; w_num = w_p2[TIME_BITS-1:0]; w_den = r_fall;
            w_from = r_peak;
        end else begin
            w_seg = SEG_BASE;
        end
    end

    logic r_b_v;
    t_seg r_b_seg;
    logic [TIME_BITS-1:0] r_b_num, r_b_den;
    logic signed [LEVEL_BITS-1:0] r_b_from, r_b_to;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_v <= 1'b0;
        else if (w_en) r_b_v <= w_m_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_seg <= w_seg; r_b_num <= w_num; r_b_den <= w_den;
            r_b_from <= w_from; r_b_to <= w_to;
        end
    end

    // Stage C: magnitude times phase (one LEVEL_BITS+1 by TIME_BITS multiplier).
    logic signed [DW-1:0] w_diff;
    logic w_neg;
    logic [DW-1:0] w_mag;
    assign w_diff = DW'(r_b_to) - DW'(r_b_from);
    assign w_neg  = w_diff[DW-1];
    assign w_mag  = w_neg ? DW'(-w_diff) : w_diff;

    logic r_c_v;
    logic [PW-1:0] r_c_prod;
    logic [TIME_BITS-1:0] r_c_den;
    logic [SW-1:0] r_c_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c_v <= 1'b0;
        else if (w_en) r_c_v <= r_b_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_prod <= PW'(w_mag) * PW'(r_b_num);
            r_c_den  <= r_b_den;
            // Sideband: level to use directly, ramp start, ramp flag, sign.
            r_c_side <= {(r_b_seg == SEG_PEAK) ? r_b_to : r_b_from, r_b_from,
                         (r_b_seg == SEG_RISE) || (r_b_seg == SEG_FALL), w_neg};
        end
    end

    logic w_d_v;
    logic [PW-1:0] w_d_q;
    logic [TIME_BITS-1:0] w_d_r;
    logic [SW-1:0] w_d_side;
    ppw_divider #(.NUM_BITS(PW), .DEN_BITS(TIME_BITS), .SIDE_BITS(SW)) u_ramp (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r_c_v), .i_num(r_c_prod),
        .i_den(r_c_den), .i_side(r_c_side), .o_valid(w_d_v), .o_quot(w_d_q),
        .o_rem(w_d_r), .o_side(w_d_side)
    );

    // Output stage: apply the quotient to the ramp start, or pass the held level when not ramping.
    logic signed [LEVEL_BITS-1:0] w_from_d, w_hold_d;
    logic [LEVEL_BITS-1:0] w_q;
    assign w_hold_d = w_d_side[SW-1:SW-LEVEL_BITS];
    assign w_from_d = w_d_side[SW-LEVEL_BITS-1:2];
    assign w_q = w_d_q[LEVEL_BITS-1:0];

    logic r_o_v;
    logic signed [LEVEL_BITS-1:0] r_o_lvl;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_v <= 1'b0;
        else if (w_en) r_o_v <= w_d_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (!w_d_side[1]) r_o_lvl <= w_hold_d;
            else if (w_d_side[0]) r_o_lvl <= w_from_d - w_q;
            else r_o_lvl <= w_from_d + w_q;
        end
    end
    assign o_out_valid = r_o_v;
    assign o_level_out = r_o_lvl;

    logic w_unused;
    assign w_unused = ^{w_m_q, w_d_r, w_d_q, w_p1[TIME_BITS], w_p2[TIME_BITS]};

    `PPW_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_level_out))
    `PPW_ASSERT_IMP(a_ready, i_clk, i_rst_n, !o_out_valid, o_in_ready)
    `PPW_ASSERT_IMP(a_quot, i_clk, i_rst_n, w_d_v && w_d_side[1],
        w_d_q[PW-1:LEVEL_BITS] == '0)
endmodule
